@@ rtl/core/clt_pkg.sv @@
// shared types, character codes and constants of the command-line tokenizer
package clt_pkg;

   // default depth of the queue between front and back and of the result queue
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHR_TAB       = 8'h09;
   localparam logic [7:0] CHR_LF        = 8'h0A;
   localparam logic [7:0] CHR_CR        = 8'h0D;
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] CHR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHR_SEMI      = 8'h3B;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHR_LOWER_B   = 8'h62;
   localparam logic [7:0] CHR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHR_LOWER_X   = 8'h78;
   localparam logic [7:0] CHR_BELL      = 8'h07;
   localparam logic [7:0] CHR_BSPACE    = 8'h08;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_ESCAPE   = 3'd1,
      ERR_NO_SPACE = 3'd2,
      ERR_LINE_END = 3'd3,
      ERR_QUOTE    = 3'd4
   } clt_error_type;

   typedef enum logic [3:0] {
      CLS_OTHER     = 4'd0,
      CLS_BLANK     = 4'd1,
      CLS_DQUOTE    = 4'd2,
      CLS_SQUOTE    = 4'd3,
      CLS_CR        = 4'd4,
      CLS_LF        = 4'd5,
      CLS_SEMI      = 4'd6,
      CLS_BACKSLASH = 4'd7,
      CLS_X         = 4'd8
   } clt_class_type;

   typedef enum logic [10:0] {
      ST_INITIAL = 11'b000_0000_0001,
      ST_TEXT    = 11'b000_0000_0010,
      ST_CR      = 11'b000_0000_0100,
      ST_CR_TEXT = 11'b000_0000_1000,
      ST_ESC     = 11'b000_0001_0000,
      ST_HEX_HI  = 11'b000_0010_0000,
      ST_HEX_LO  = 11'b000_0100_0000,
      ST_SQ      = 11'b000_1000_0000,
      ST_SQ_ESC  = 11'b001_0000_0000,
      ST_DQ      = 11'b010_0000_0000,
      ST_AFTER_Q = 11'b100_0000_0000
   } clt_state_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
   } clt_req_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data_out;
      logic       token_end;
      logic       line_done;
      logic [2:0] error_code;
   } clt_rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic          view_end;
      clt_class_type char_class;
      logic          hex_ok;
      logic [3:0]    hex_value;
      logic [7:0]    raw_byte;
      logic [7:0]    unescaped;
   } clt_item_type;

endpackage

@@ rtl/core/clt_fifo.sv @@
// small synchronous queue of a generic item type
module clt_fifo #(
   parameter type item_type = logic,
   parameter int  Depth     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   // depth of two or more
   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   item_type            mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                wr_en, rd_en;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign wr_en    = push && !full;
   assign rd_en    = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/clt_front.sv @@
// front end: accepts input transactions and classifies each byte
module clt_front (
   input  clt_pkg::clt_req_type  req_payload,
   input  logic                  req_push,
   output logic                  req_full,
   output logic                  q_push,
   output clt_pkg::clt_item_type q_data,
   input  logic                  q_full
);
   import clt_pkg::*;

   logic [7:0] c;

   assign c        = req_payload.data_byte;
   assign req_full = q_full;
   assign q_push   = req_push;

   always_comb begin
      q_data           = '0;
      q_data.view_end  = req_payload.operation;
      q_data.raw_byte  = c;

      case (c)
         CHR_SPACE, CHR_TAB: q_data.char_class = CLS_BLANK;
         CHR_DQUOTE:         q_data.char_class = CLS_DQUOTE;
         CHR_SQUOTE:         q_data.char_class = CLS_SQUOTE;
         CHR_CR:             q_data.char_class = CLS_CR;
         CHR_LF:             q_data.char_class = CLS_LF;
         CHR_SEMI:           q_data.char_class = CLS_SEMI;
         CHR_BACKSLASH:      q_data.char_class = CLS_BACKSLASH;
         CHR_LOWER_X:        q_data.char_class = CLS_X;
         default:            q_data.char_class = CLS_OTHER;
      endcase

      // hex digit value
      if (c inside {[8'h30:8'h39]}) begin
         q_data.hex_ok    = 1'b1;
         q_data.hex_value = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         q_data.hex_ok    = 1'b1;
         q_data.hex_value = c[3:0] + 4'd9;
      end else begin
         q_data.hex_ok    = 1'b0;
         q_data.hex_value = '0;
      end

      // single-letter escapes inside double quotes
      case (c)
         CHR_LOWER_N: q_data.unescaped = CHR_LF;
         CHR_LOWER_R: q_data.unescaped = CHR_CR;
         CHR_LOWER_T: q_data.unescaped = CHR_TAB;
         CHR_LOWER_B: q_data.unescaped = CHR_BSPACE;
         CHR_LOWER_A: q_data.unescaped = CHR_BELL;
         default:     q_data.unescaped = c;
      endcase
   end

endmodule

@@ rtl/core/clt_back.sv @@
// back end: parse state machine, one classified item per cycle while the result queue is not full
module clt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  lf_on_view_end,
   input  logic                  item_valid,
   input  clt_pkg::clt_item_type item,
   output logic                  item_pop,
   output logic                  res_push,
   output clt_pkg::clt_rsp_type  res_data,
   input  logic                  res_full
);
   import clt_pkg::*;

   clt_state_type state_ff, state_in;
   logic [3:0]    nibble_ff, nibble_in;

   clt_class_type cls;
   logic          can_end;
   logic          view_err;
   logic          produce;
   clt_rsp_type   res;

   // plain-text handling shared by initial and text states
   clt_state_type text_state;
   logic          text_produce;
   clt_rsp_type   text_res;

   assign item_pop = item_valid && !res_full;
   assign res_push = item_pop && produce;
   assign res_data = res;

   assign can_end = state_ff inside {ST_INITIAL, ST_TEXT, ST_CR, ST_CR_TEXT, ST_AFTER_Q};

   always_comb begin
      cls      = item.char_class;
      view_err = 1'b0;
      if (item.view_end) begin
         if (lf_on_view_end && can_end) begin
            cls = CLS_LF;
         end else begin
            view_err = 1'b1;
         end
      end
   end

   always_comb begin
      text_state   = ST_TEXT;
      text_produce = 1'b0;
      text_res     = '0;
      case (cls)
         CLS_BLANK: begin
            text_state         = ST_INITIAL;
            text_produce       = 1'b1;
            text_res.token_end = 1'b1;
         end
         CLS_DQUOTE: text_state = ST_DQ;
         CLS_SQUOTE: text_state = ST_SQ;
         CLS_CR:     text_state = ST_CR_TEXT;
         CLS_SEMI, CLS_LF: begin
            text_state         = ST_INITIAL;
            text_produce       = 1'b1;
            text_res.token_end = 1'b1;
            text_res.line_done = 1'b1;
         end
         default: begin
            text_produce        = 1'b1;
            text_res.byte_valid = 1'b1;
            text_res.data_out   = item.raw_byte;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      nibble_in = nibble_ff;
      produce   = 1'b0;
      res       = '0;

      if (view_err) begin
         produce = 1'b1;
         case (state_ff)
            ST_ESC, ST_HEX_HI, ST_HEX_LO, ST_SQ_ESC: res.error_code = ERR_ESCAPE;
            ST_SQ, ST_DQ:                           res.error_code = ERR_QUOTE;
            ST_AFTER_Q:                             res.error_code = ERR_NO_SPACE;
            default:                                res.error_code = ERR_LINE_END;
         endcase
      end else begin
         case (state_ff)
            ST_TEXT: begin
               state_in = text_state;
               produce  = text_produce;
               res      = text_res;
            end
            ST_CR: begin
               produce = 1'b1;
               if (cls == CLS_LF) begin
                  state_in      = ST_INITIAL;
                  res.line_done = 1'b1;
               end else begin
                  res.error_code = ERR_LINE_END;
               end
            end
            ST_CR_TEXT: begin
               produce = 1'b1;
               if (cls == CLS_LF) begin
                  state_in      = ST_INITIAL;
                  res.token_end = 1'b1;
                  res.line_done = 1'b1;
               end else begin
                  res.error_code = ERR_LINE_END;
               end
            end
            ST_ESC: begin
               if (cls inside {CLS_SEMI, CLS_CR, CLS_LF}) begin
                  produce        = 1'b1;
                  res.error_code = ERR_LINE_END;
               end else if (cls == CLS_X) begin
                  state_in = ST_HEX_HI;
               end else begin
                  state_in       = ST_DQ;
                  produce        = 1'b1;
                  res.byte_valid = 1'b1;
                  res.data_out   = item.unescaped;
               end
            end
            ST_HEX_HI: begin
               if (!item.hex_ok) begin
                  produce        = 1'b1;
                  res.error_code = ERR_ESCAPE;
               end else begin
                  nibble_in = item.hex_value;
                  state_in  = ST_HEX_LO;
               end
            end
            ST_HEX_LO: begin
               produce = 1'b1;
               if (!item.hex_ok) begin
                  res.error_code = ERR_ESCAPE;
               end else begin
                  state_in       = ST_DQ;
                  res.byte_valid = 1'b1;
                  res.data_out   = {nibble_ff, item.hex_value};
               end
            end
            ST_SQ: begin
               if (cls inside {CLS_SEMI, CLS_CR, CLS_LF}) begin
                  produce        = 1'b1;
                  res.error_code = ERR_QUOTE;
               end else if (cls == CLS_BACKSLASH) begin
                  state_in = ST_SQ_ESC;
               end else if (cls == CLS_SQUOTE) begin
                  state_in = ST_AFTER_Q;
               end else begin
                  produce        = 1'b1;
                  res.byte_valid = 1'b1;
                  res.data_out   = item.raw_byte;
               end
            end
            ST_SQ_ESC: begin
               produce = 1'b1;
               if (cls == CLS_SQUOTE) begin
                  state_in       = ST_SQ;
                  res.byte_valid = 1'b1;
                  res.data_out   = item.raw_byte;
               end else begin
                  res.error_code = ERR_ESCAPE;
               end
            end
            ST_DQ: begin
               if (cls inside {CLS_SEMI, CLS_CR, CLS_LF}) begin
                  produce        = 1'b1;
                  res.error_code = ERR_QUOTE;
               end else if (cls == CLS_DQUOTE) begin
                  state_in = ST_AFTER_Q;
               end else if (cls == CLS_BACKSLASH) begin
                  state_in = ST_ESC;
               end else begin
                  produce        = 1'b1;
                  res.byte_valid = 1'b1;
                  res.data_out   = item.raw_byte;
               end
            end
            ST_AFTER_Q: begin
               case (cls)
                  CLS_CR: state_in = ST_CR_TEXT;
                  CLS_BLANK: begin
                     state_in      = ST_INITIAL;
                     produce       = 1'b1;
                     res.token_end = 1'b1;
                  end
                  CLS_SEMI, CLS_LF: begin
                     state_in      = ST_INITIAL;
                     produce       = 1'b1;
                     res.token_end = 1'b1;
                     res.line_done = 1'b1;
                  end
                  default: begin
                     produce        = 1'b1;
                     res.error_code = ERR_NO_SPACE;
                  end
               endcase
            end
            default: begin
               // initial state
               case (cls)
                  CLS_BLANK: state_in = ST_INITIAL;
                  CLS_CR:    state_in = ST_CR;
                  CLS_SEMI, CLS_LF: begin
                     state_in      = ST_INITIAL;
                     produce       = 1'b1;
                     res.line_done = 1'b1;
                  end
                  default: begin
                     state_in = text_state;
                     produce  = text_produce;
                     res      = text_res;
                  end
               endcase
            end
         endcase
      end

      // any error restarts the line
      if (res.error_code != ERR_NONE) begin
         state_in  = ST_INITIAL;
         nibble_in = '0;
      end else if (res.line_done) begin
         nibble_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INITIAL;
         nibble_ff <= '0;
      end else if (item_pop) begin
         state_ff  <= state_in;
         nibble_ff <= nibble_in;
      end
   end

endmodule

@@ rtl/core/command_line_tokenizer.sv @@
// top level of the command-line tokenizer
// Command-line tokenizer. Bytes of a command line go in as input transactions
// (operation 0 with data_byte, or operation 1 for end of view) and come out
// as result transactions: one token byte, a token-end mark, a line-done mark
// or an error code; a byte that yields nothing gives no result. Both sides
// look like queues: push while full is low, pop while empty is low. The
// block takes one input transaction per cycle while req_full is low and
// writes at most one result per cycle while the result queue is not full.
// An accepted byte is classified and registered in the middle queue; the
// single-step parse state machine works on it there, and its result is
// registered in the result queue. After an error the bytes already
// sent for the line are to be dropped by the consumer and parsing restarts.
// The end-of-view line feed mode is to be written through csr_ only while
// the block is idle, which it does not enforce. No start-up pass after reset.
module command_line_tokenizer #(
   parameter int QueueDepth = clt_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   // input transactions
   input  logic                 req_push,
   input  clt_pkg::clt_req_type req_payload,
   output logic                 req_full,
   // result transactions
   output logic                 rsp_empty,
   output clt_pkg::clt_rsp_type rsp_payload,
   input  logic                 rsp_pop,
   // configuration
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data
);
   import clt_pkg::*;

   logic         inject_ff, inject_in;

   // front to queue
   logic         mid_push, mid_full, mid_empty, mid_pop;
   clt_item_type mid_in_data, mid_out_data;

   // back to result queue
   logic         res_push, res_full;
   clt_rsp_type  res_data;

   // configuration register: end of view acts as line feed
   assign inject_in = csr_wr_en ? csr_wr_data : inject_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inject_ff <= 1'b0;
      end else begin
         inject_ff <= inject_in;
      end
   end

   // classify each byte as it is accepted
   clt_front u_front (
      .req_payload (req_payload),
      .req_push    (req_push),
      .req_full    (req_full),
      .q_push      (mid_push),
      .q_data      (mid_in_data),
      .q_full      (mid_full)
   );

   // short queue decoupling classifier and parser
   clt_fifo #(
      .item_type (clt_item_type),
      .Depth     (QueueDepth)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out_data),
      .empty     (mid_empty)
   );

   // parse state machine, stalls only when the result queue is full
   clt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .lf_on_view_end (inject_ff),
      .item_valid     (!mid_empty),
      .item           (mid_out_data),
      .item_pop       (mid_pop),
      .res_push       (res_push),
      .res_data       (res_data),
      .res_full       (res_full)
   );

   // result queue, keeps taking input while it is not full, also while a result waits to be popped
   clt_fifo #(
      .item_type (clt_rsp_type),
      .Depth     (QueueDepth)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_payload),
      .empty     (rsp_empty)
   );

`ifndef NO_ASSERTIONS
   // an error result carries no byte and no marks
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_payload.error_code != ERR_NONE) |->
      (!rsp_payload.byte_valid && !rsp_payload.token_end && !rsp_payload.line_done))
      else $error("error result carries other content");

   // data_out is zero unless it carries a token byte
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_payload.byte_valid) |-> (rsp_payload.data_out == 8'h00))
      else $error("stray data_out without byte_valid");

   // a transaction taken into an empty queue is still waiting there in the next cycle
   a_mid_holds: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && mid_empty) |=> !mid_empty)
      else $error("accepted transaction lost in front queue");
`endif

endmodule
